FILE: hdl/quoted_field_splitter_unit_macros.svh
// assertion macros for the quoted field splitter
// no dependencies; included by the modules that carry assertions
`ifndef QUOTED_FIELD_SPLITTER_UNIT_MACROS_SVH
`define QUOTED_FIELD_SPLITTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qfs assertion failed");

// next-cycle implication, disabled during reset
`define QFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qfs assertion failed");

`endif

FILE: hdl/qfs_pkg.sv
// shared types and constants of the quoted field splitter
// no dependencies
`default_nettype none

package qfs_pkg;

    localparam int unsigned PENDING_DEPTH_DEF = 32;

    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] DELIM_RESET = 8'h3A;

    typedef enum logic [4:0] {
        OUT_NONE      = 5'b00001,
        OUT_CHAR_IN   = 5'b00010,
        OUT_CHAR_HELD = 5'b00100,
        OUT_BLANK     = 5'b01000,
        OUT_FEND      = 5'b10000
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     push_blank;
        logic     start_flush;
        logic     flush_step;
        logic     clear_count;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_ovf;
        logic     out_rec;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic in_kind;
        logic is_quote;
        logic is_delim;
        logic is_crlf;
        logic is_nul;
        logic is_blank;
        logic count_zero;
        logic count_full;
        logic flush_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/qfs_ifs.sv
// valid/ready channel interfaces for input bytes and result items
// no dependencies
`default_nettype none

interface qfs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_in;

    modport source (output valid, kind, char_in, input ready);
    modport sink (input valid, kind, char_in, output ready);
endinterface

interface qfs_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       has_char;
    logic       field_end;
    logic       record_end;
    logic       overflow;
    logic       last;

    modport source (output valid, char_out, has_char, field_end, record_end, overflow, last,
                    input ready);
    modport sink (input valid, char_out, has_char, field_end, record_end, overflow, last,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/qfs_datapath.sv
// datapath: delimiter register, byte classification, blank buffer, output register
// depends on qfs_pkg, qfs_ifs and the assertion macro header
`default_nettype none
`include "quoted_field_splitter_unit_macros.svh"

module qfs_datapath
    import qfs_pkg::*;
#(
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_data,
    input  wire logic         i_kind,
    input  wire logic [7:0]   i_char,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_stat          o_stat,
    qfs_res_if.source         o_res
);

    localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(PENDING_DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [7:0]    r_delim;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] n_rd_idx;
    logic [7:0]    r_hold_char;
    logic          r_rd_tab;
    logic          r_mem [PENDING_DEPTH];
    logic          r_out_valid;
    logic [7:0]    r_char_out;
    logic          r_has_char;
    logic          r_field_end;
    logic          r_record_end;
    logic          r_overflow;
    logic          r_last;
    logic          w_out_free;

    assign w_out_free = !r_out_valid || o_res.ready;

    always_comb begin
        o_stat.in_kind    = i_kind;
        o_stat.is_quote   = (i_char == CH_QUOTE);
        o_stat.is_delim   = (i_char == r_delim);
        o_stat.is_crlf    = (i_char == CH_CR) || (i_char == CH_LF);
        o_stat.is_nul     = (i_char == CH_NUL);
        o_stat.is_blank   = (i_char == CH_SPACE) || (i_char == CH_TAB);
        o_stat.count_zero = (r_count == '0);
        o_stat.count_full = (r_count == CNT_FULL);
        o_stat.flush_last = ((r_rd_idx + CNT_ONE) == r_count);
        o_stat.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg_we) begin
            r_delim <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_count) begin
            r_count <= '0;
        end else if (i_cmd.push_blank) begin
            r_count <= r_count + CNT_ONE;
        end
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.start_flush) begin
            n_rd_idx = '0;
        end else if (i_cmd.flush_step) begin
            n_rd_idx = r_rd_idx + CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else begin
            r_rd_idx <= n_rd_idx;
        end
    end

    // blank buffer keeps one bit per entry: tab or space
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_blank) begin
            r_mem[r_count[AW-1:0]] <= (i_char == CH_TAB);
        end
        r_rd_tab <= r_mem[n_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hold_char <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_overflow   <= i_cmd.out_ovf;
            r_record_end <= i_cmd.out_rec;
            r_last       <= i_cmd.out_last;
            unique case (i_cmd.out_sel)
                OUT_CHAR_IN: begin
                    r_char_out  <= i_char;
                    r_has_char  <= 1'b1;
                    r_field_end <= 1'b0;
                end
                OUT_CHAR_HELD: begin
                    r_char_out  <= r_hold_char;
                    r_has_char  <= 1'b1;
                    r_field_end <= 1'b0;
                end
                OUT_BLANK: begin
                    r_char_out  <= r_rd_tab ? CH_TAB : CH_SPACE;
                    r_has_char  <= 1'b1;
                    r_field_end <= 1'b0;
                end
                OUT_FEND: begin
                    r_char_out  <= '0;
                    r_has_char  <= 1'b0;
                    r_field_end <= 1'b1;
                end
                default: begin
                    r_char_out  <= '0;
                    r_has_char  <= 1'b0;
                    r_field_end <= 1'b0;
                end
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.char_out   = r_char_out;
    assign o_res.has_char   = r_has_char;
    assign o_res.field_end  = r_field_end;
    assign o_res.record_end = r_record_end;
    assign o_res.overflow   = r_overflow;
    assign o_res.last       = r_last;

    `QFS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `QFS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, i_cmd.out_load, w_out_free)
    `QFS_ASSERT_SAME(a_flush_nonempty, i_clk, i_rst_n, i_cmd.start_flush, r_count != '0)
    `QFS_ASSERT_SAME(a_step_in_range, i_clk, i_rst_n, i_cmd.flush_step, r_rd_idx < r_count)
    `QFS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_cmd.push_blank && !i_cmd.clear_count,
                     r_count == $past(r_count) + CNT_ONE)

endmodule

`default_nettype wire

FILE: hdl/qfs_controller.sv
// controller: parse mode, field flags and the flush sequencer
// depends on qfs_pkg
`default_nettype none

module qfs_controller
    import qfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_CHAR  = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        MODE_OUT   = 4'b0001,
        MODE_IN    = 4'b0010,
        MODE_QSEEN = 4'b0100,
        MODE_DONE  = 4'b1000
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_nonempty, n_nonempty;
    logic   r_started, n_started;

    always_comb begin
        t_mode m;
        logic  accept;
        logic  do_add;
        logic  do_end;
        logic  end_rec;

        n_state    = r_state;
        n_mode     = r_mode;
        n_nonempty = r_nonempty;
        n_started  = r_started;
        o_cmd      = '0;
        o_cmd.out_sel = OUT_NONE;
        o_in_ready = 1'b0;
        m       = r_mode;
        accept  = 1'b0;
        do_add  = 1'b0;
        do_end  = 1'b0;
        end_rec = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_stat.out_free;
                accept     = i_in_valid && i_stat.out_free;
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = OUT_BLANK;
                    o_cmd.flush_step = 1'b1;
                    if (i_stat.flush_last) begin
                        n_state = ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_sel     = OUT_CHAR_HELD;
                    o_cmd.out_last    = 1'b1;
                    o_cmd.clear_count = 1'b1;
                    n_started         = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (accept) begin
            o_cmd.capture = 1'b1;
            if (r_mode == MODE_DONE) begin
                if (i_stat.in_kind) begin
                    n_mode = MODE_OUT;
                end
            end else if (r_mode == MODE_QSEEN && !i_stat.in_kind && i_stat.is_quote) begin
                do_add = 1'b1;
                n_mode = MODE_IN;
            end else begin
                m      = (r_mode == MODE_QSEEN) ? MODE_OUT : r_mode;
                n_mode = m;
                priority if (i_stat.in_kind) begin
                    do_end  = 1'b1;
                    end_rec = 1'b1;
                    n_mode  = MODE_OUT;
                end else if (i_stat.is_nul) begin
                    do_end  = 1'b1;
                    end_rec = 1'b1;
                    n_mode  = MODE_DONE;
                end else if (m == MODE_OUT && !r_nonempty && i_stat.is_quote) begin
                    n_mode = MODE_IN;
                end else if (m == MODE_IN && i_stat.is_quote) begin
                    n_mode = MODE_QSEEN;
                end else if (m == MODE_OUT && i_stat.is_delim) begin
                    do_end = 1'b1;
                end else if (m == MODE_OUT && i_stat.is_crlf) begin
                    do_end  = 1'b1;
                    end_rec = 1'b1;
                    n_mode  = MODE_DONE;
                end else begin
                    do_add = 1'b1;
                end
            end
        end

        if (do_end) begin
            o_cmd.out_load    = 1'b1;
            o_cmd.out_sel     = OUT_FEND;
            o_cmd.out_rec     = end_rec;
            o_cmd.out_last    = 1'b1;
            o_cmd.clear_count = 1'b1;
            n_nonempty        = 1'b0;
            n_started         = 1'b0;
        end

        if (do_add) begin
            n_nonempty = 1'b1;
            if (i_stat.is_blank) begin
                if (r_started) begin
                    if (!i_stat.count_full) begin
                        o_cmd.push_blank = 1'b1;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ovf  = 1'b1;
                        o_cmd.out_last = 1'b1;
                    end
                end
            end else if (i_stat.count_zero) begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel  = OUT_CHAR_IN;
                o_cmd.out_last = 1'b1;
                n_started      = 1'b1;
            end else begin
                o_cmd.start_flush = 1'b1;
                n_state           = ST_FLUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= MODE_OUT;
            r_nonempty <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_nonempty <= n_nonempty;
            r_started  <= n_started;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/quoted_field_splitter_unit.sv
// Quoted field splitter, top level.
// Input channel i_in: one item per transfer, kind 0 carries a line byte in char_in,
// kind 1 marks the end of the line. Output channel o_res: one result per transfer,
// a field byte, a field end (with record_end on the one that closes the record) or
// an overflow flag; last marks the final result of an input item.
// The delimiter register is written through i_cfg_we / i_cfg_data; the user must
// do so only while idle, which the block does not enforce. Results come from an
// output register; a single result is valid in the cycle after its input transfer.
// An item that gives no result or a single result leaves the controller idle, so
// a byte may follow every cycle. A non-blank byte that releases n waiting blanks
// makes the controller walk the blank buffer one entry per cycle through its single
// registered read port, then send the byte. Reset returns to outside quotes with an
// empty field, delimiter ':', no waiting blanks and an empty output register.
// When o_res.ready is low the output register holds its result, the buffer walk
// pauses and i_in.ready stays low until the register can be loaded again.
// depends on qfs_pkg, qfs_ifs, qfs_controller and qfs_datapath
`default_nettype none

module quoted_field_splitter_unit
    import qfs_pkg::*;
#(
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    qfs_in_if.sink          i_in,
    qfs_res_if.source       o_res
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    qfs_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    qfs_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_in.kind),
        .i_char     (i_in.char_in),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire
